>>> sv/bbiq_pkg.sv
// Package for the block bitmap interval query block.
// Holds the command and result word types, opcodes and size constants; no dependencies.
package bbiq_pkg;

	localparam int unsigned MAX_BITMAP_BYTES = 4096;
	localparam int unsigned LEN_W  = 13;
	localparam int unsigned ADDR_W = 12;
	localparam logic [31:0] BLOCK_BYTES_RESET = 32'd4096;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_APPEND = 3'd1;
	localparam logic [2:0] OP_AND    = 3'd2;
	localparam logic [2:0] OP_OR     = 3'd3;
	localparam logic [2:0] OP_QUERY  = 3'd4;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [11:0] byte_index;
		logic [7:0]  byte_value;
		logic [47:0] query_offset;
		logic [47:0] query_length;
	} cmd_word_t;

	typedef struct packed {
		logic        hit;
		logic        beyond_end;
		logic        status;
		logic [12:0] bitmap_bytes;
	} res_word_t;

endpackage

>>> sv/block_bitmap_interval_query.sv
// Top level of the block bitmap interval query block: bitmap store, shared divider, sequencer.
// Depends on bbiq_pkg for the command and result word types and opcodes.
//
//   channel   signals                       handshake
//   command   start, busy, cmd              taken at an edge with start high and busy low
//   result    done, result                  one word per command, valid for one cycle with done
//   config    cfg_we, cfg_wdata             block size written at an edge with cfg_we high
//
// Clear, append and unused opcodes finish in the idle state; their result appears in the cycle
// after the command is taken and busy never rises. And and or merges into an existing byte
// pass through the merge state, which waits on the read port of the bitmap memory. A query
// runs the one restoring divider twice, for the start and end block numbers, then does the
// range check, and then scans each bitmap byte in the range through a read state and a check
// state. Reset empties the bitmap and sets the block size to 4096; the memory itself is not
// cleared. The receiver cannot stall.
module block_bitmap_interval_query (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  bbiq_pkg::cmd_word_t cmd,
	output logic                done,
	output bbiq_pkg::res_word_t result,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_wdata
);
	import bbiq_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_MERGE = 7'b0000010,
		ST_DIVO  = 7'b0000100,
		ST_DIVE  = 7'b0001000,
		ST_CHECK = 7'b0010000,
		ST_RD    = 7'b0100000,
		ST_CHK   = 7'b1000000
	} state_t;

	state_t state_q;
	cmd_word_t cmd_q;
	res_word_t result_q;
	logic done_q;
	logic [LEN_W-1:0] len_q;
	logic [31:0] block_bytes_q;

	// Bitmap memory with a registered read port.
	logic [7:0] mem [MAX_BITMAP_BYTES];
	logic [7:0] rd_data_q;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [7:0] wr_data;
	logic wr_en;

	// Shared restoring divider state.
	logic [48:0] dvd_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic [48:0] first_q;
	logic [49:0] last_q;
	logic [14:0] lastm1_q;
	logic [ADDR_W-1:0] scan_q;

	logic [31:0] divisor;
	logic [32:0] rem_sh;
	logic        ge;
	logic [32:0] rem_diff;
	logic [31:0] rem_n;
	logic [48:0] dvd_n;
	logic [7:0]  mask_lo, mask_hi;
	logic        full;

	assign divisor  = (block_bytes_q == 32'd0) ? 32'd1 : block_bytes_q;
	assign rem_sh   = {rem_q, dvd_q[48]};
	assign ge       = rem_sh >= {1'b0, divisor};
	assign rem_diff = rem_sh - {1'b0, divisor};
	assign rem_n    = ge ? rem_diff[31:0] : rem_sh[31:0];
	assign dvd_n    = {dvd_q[47:0], ge};
	assign full     = len_q >= LEN_W'(MAX_BITMAP_BYTES);

	// Bits of the scanned byte that lie inside the block range.
	assign mask_lo = (scan_q == first_q[14:3]) ? (8'hFF << first_q[2:0]) : 8'hFF;
	assign mask_hi = (scan_q == lastm1_q[14:3]) ? (8'hFF >> (3'd7 - lastm1_q[2:0])) : 8'hFF;

	assign rd_addr = (state_q == ST_IDLE) ? cmd.byte_index : scan_q;
	assign busy    = state_q != ST_IDLE;
	assign done    = done_q;
	assign result  = result_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = len_q[ADDR_W-1:0];
		wr_data = cmd.byte_value;
		if (state_q == ST_IDLE && start) begin
			if (cmd.opcode == OP_APPEND && !full) begin
				wr_en = 1'b1;
			end else if ((cmd.opcode == OP_AND || cmd.opcode == OP_OR) &&
					{1'b0, cmd.byte_index} == len_q && !full) begin
				wr_en = 1'b1;
			end
		end else if (state_q == ST_MERGE) begin
			wr_en   = 1'b1;
			wr_addr = cmd_q.byte_index;
			wr_data = (cmd_q.opcode == OP_AND) ? (rd_data_q & cmd_q.byte_value)
			                                   : (rd_data_q | cmd_q.byte_value);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		res_word_t res_n;
		logic      done_n;
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			done_q        <= 1'b0;
			len_q         <= '0;
			block_bytes_q <= BLOCK_BYTES_RESET;
		end else begin
			res_n  = result_q;
			done_n = 1'b0;
			if (cfg_we) begin
				block_bytes_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						res_n = '0;
						res_n.bitmap_bytes = len_q;
						case (cmd.opcode)
							OP_CLEAR: begin
								len_q <= '0;
								res_n.bitmap_bytes = '0;
								done_n = 1'b1;
							end
							OP_APPEND: begin
								if (full) begin
									res_n.status = 1'b1;
								end else begin
									len_q <= len_q + 1'b1;
									res_n.bitmap_bytes = len_q + 1'b1;
								end
								done_n = 1'b1;
							end
							OP_AND, OP_OR: begin
								if ({1'b0, cmd.byte_index} < len_q) begin
									state_q <= ST_MERGE;
								end else if ({1'b0, cmd.byte_index} == len_q && !full) begin
									len_q <= len_q + 1'b1;
									res_n.bitmap_bytes = len_q + 1'b1;
									done_n = 1'b1;
								end else begin
									res_n.status = 1'b1;
									done_n = 1'b1;
								end
							end
							OP_QUERY: begin
								dvd_q   <= {1'b0, cmd.query_offset};
								rem_q   <= '0;
								cnt_q   <= '0;
								state_q <= ST_DIVO;
							end
							default: begin
								done_n = 1'b1;
							end
						endcase
					end
				end
				ST_MERGE: begin
					done_n = 1'b1;
					state_q <= ST_IDLE;
				end
				ST_DIVO: begin
					if (cnt_q == 6'd48) begin
						first_q <= dvd_n;
						dvd_q   <= {1'b0, cmd_q.query_offset} + {1'b0, cmd_q.query_length};
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIVE;
					end else begin
						dvd_q <= dvd_n;
						rem_q <= rem_n;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIVE: begin
					dvd_q <= dvd_n;
					rem_q <= rem_n;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd48) begin
						last_q  <= {1'b0, dvd_n} + {49'd0, (rem_n != 32'd0)};
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (last_q[49:3] >= {34'd0, len_q}) begin
						res_n.hit = 1'b1;
						res_n.beyond_end = 1'b1;
						done_n = 1'b1;
						state_q <= ST_IDLE;
					end else if ({1'b0, first_q} >= last_q) begin
						done_n = 1'b1;
						state_q <= ST_IDLE;
					end else begin
						// The range lies below the length, so it fits in 15 bits here.
						scan_q   <= first_q[14:3];
						lastm1_q <= last_q[14:0] - 15'd1;
						state_q  <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if ((rd_data_q & mask_lo & mask_hi) != 8'd0) begin
						res_n.hit = 1'b1;
						done_n = 1'b1;
						state_q <= ST_IDLE;
					end else if (scan_q == lastm1_q[14:3]) begin
						done_n = 1'b1;
						state_q <= ST_IDLE;
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			done_q   <= done_n;
			result_q <= res_n;
		end
	end

endmodule
